/* rtl/rfp_pkg.sv */
`timescale 1ns / 1ps
package rfp_pkg;

	localparam logic [7:0]  TYPE_NACK     = 8'd205;
	localparam logic [7:0]  TYPE_PLI      = 8'd206;
	localparam logic [4:0]  FMT_GENERIC   = 5'd1;
	localparam logic [1:0]  RTCP_VERSION  = 2'd2;
	localparam logic [15:0] NACK_MIN_SIZE = 16'd16;
	localparam logic [15:0] PLI_MIN_SIZE  = 16'd12;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		EV_NACK   = 2'd0,
		EV_PLI    = 2'd1,
		EV_STATUS = 2'd2
	} event_kind_t;

	typedef struct packed {
		event_kind_t kind;
		logic [31:0] ssrc;
		logic [15:0] packet_id;
		logic [15:0] mask;
		logic        ok;
		logic        last;
	} result_t;

	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t e0;
		result_t e1;
	} push_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} head_t;

endpackage

/* rtl/rfp_front.sv */
`timescale 1ns / 1ps
module rfp_front
	import rfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic [15:0] datagram_length,
	input  logic        end_of_datagram,
	output push_t       push
);

	logic [15:0] offset_q, expected_q, size_q;
	logic [16:0] start_q;
	logic [4:0]  fmt_q;
	logic [7:0]  type_q;
	logic [31:0] ssrc_q, entry_q;
	logic        failed_q, trailing_q;

	logic [15:0] offset_n, expected_n, size_n, be_eff, rel, words;
	logic [16:0] start_n, received;
	logic [18:0] size_calc;
	logic [4:0]  fmt_n;
	logic [7:0]  type_n;
	logic [31:0] ssrc_n, entry_n;
	logic        failed_n, trailing_n;
	logic        ev_pli, ev_nack, status_ok;
	result_t     ev_res, st_res;

	always_comb begin
		be_eff     = (offset_q == 16'd0) ? datagram_length : expected_q;
		failed_n   = failed_q | (offset_q >= be_eff);
		trailing_n = trailing_q;
		start_n    = start_q;
		size_n     = size_q;
		fmt_n      = fmt_q;
		type_n     = type_q;
		ssrc_n     = ssrc_q;
		entry_n    = entry_q;
		ev_pli     = 1'b0;
		ev_nack    = 1'b0;
		rel        = 16'(17'(offset_q) - start_q);
		words      = {entry_q[7:0], data_byte};
		size_calc  = (19'(words) + 19'd1) << 2;

		if (!failed_n && !trailing_q) begin
			case (rel)
				16'd0: begin
					if (18'(start_q) + 18'd4 > 18'(be_eff))
						trailing_n = 1'b1;
					else if (data_byte[7:6] != RTCP_VERSION)
						failed_n = 1'b1;
					else
						fmt_n = data_byte[4:0];
				end
				16'd1: type_n = data_byte;
				16'd2: entry_n = {24'd0, data_byte};
				16'd3: begin
					if (20'(start_q) + 20'(size_calc) > 20'(be_eff))
						failed_n = 1'b1;
					else
						size_n = size_calc[15:0];
				end
				default: begin
					if (rel >= 16'd8 && rel <= 16'd11)
						ssrc_n = {ssrc_q[23:0], data_byte};
					ev_pli = (rel == 16'd11) && (type_q == TYPE_PLI) &&
						(fmt_q == FMT_GENERIC) && (size_q >= PLI_MIN_SIZE);
					if (rel >= 16'd12 && type_q == TYPE_NACK && fmt_q == FMT_GENERIC &&
						size_q >= NACK_MIN_SIZE) begin
						entry_n = {entry_q[23:0], data_byte};
						ev_nack = (rel[1:0] == 2'd3);
					end
				end
			endcase
			// close the packet on its last byte
			if (!failed_n && !trailing_n && rel >= 16'd3 &&
				17'(rel) + 17'd1 == 17'(size_n))
				start_n = 17'(offset_q) + 17'd1;
		end

		received  = 17'(offset_q) + 17'd1;
		status_ok = !failed_n && !trailing_n && (received == 17'(be_eff)) &&
			(start_n == received);

		ev_res.kind      = ev_pli ? EV_PLI : EV_NACK;
		ev_res.ssrc      = ssrc_n;
		ev_res.packet_id = ev_pli ? 16'd0 : entry_n[31:16];
		ev_res.mask      = ev_pli ? 16'd0 : entry_n[15:0];
		ev_res.ok        = 1'b0;
		ev_res.last      = !end_of_datagram;

		st_res.kind      = EV_STATUS;
		st_res.ssrc      = 32'd0;
		st_res.packet_id = 16'd0;
		st_res.mask      = 16'd0;
		st_res.ok        = status_ok;
		st_res.last      = 1'b1;

		push.v0 = accept && (ev_pli || ev_nack || end_of_datagram);
		push.v1 = accept && (ev_pli || ev_nack) && end_of_datagram;
		push.e0 = (ev_pli || ev_nack) ? ev_res : st_res;
		push.e1 = st_res;

		if (end_of_datagram) begin
			offset_n   = 16'd0;
			expected_n = 16'd0;
		end else begin
			offset_n   = (offset_q != 16'hFFFF) ? offset_q + 16'd1 : offset_q;
			expected_n = be_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			expected_q <= '0;
			start_q    <= '0;
			size_q     <= '0;
			fmt_q      <= '0;
			type_q     <= '0;
			ssrc_q     <= '0;
			entry_q    <= '0;
			failed_q   <= 1'b0;
			trailing_q <= 1'b0;
		end else if (accept) begin
			offset_q   <= offset_n;
			expected_q <= expected_n;
			if (end_of_datagram) begin
				start_q    <= '0;
				size_q     <= '0;
				fmt_q      <= '0;
				type_q     <= '0;
				ssrc_q     <= '0;
				entry_q    <= '0;
				failed_q   <= 1'b0;
				trailing_q <= 1'b0;
			end else begin
				start_q    <= start_n;
				size_q     <= size_n;
				fmt_q      <= fmt_n;
				type_q     <= type_n;
				ssrc_q     <= ssrc_n;
				entry_q    <= entry_n;
				failed_q   <= failed_n;
				trailing_q <= trailing_n;
			end
		end
	end

endmodule

/* rtl/rfp_queue.sv */
`timescale 1ns / 1ps
module rfp_queue
	import rfp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output head_t head,
	output logic  full
);

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;
	logic [QCNT_W-1:0] n_push;
	logic              do_pop;

	assign n_push    = QCNT_W'(push.v0) + QCNT_W'(push.v1);
	assign do_pop    = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.data  = mem_q[rd_q];
	// hold off input unless two words fit
	assign full = (count_q > QCNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.v0)
			mem_q[wr_q] <= push.e0;
		if (push.v1)
			mem_q[QPTR_W'(wr_q + QPTR_W'(1))] <= push.e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= QPTR_W'(wr_q + QPTR_W'(n_push));
			rd_q    <= do_pop ? QPTR_W'(rd_q + QPTR_W'(1)) : rd_q;
			count_q <= count_q + n_push - QCNT_W'(do_pop);
		end
	end

endmodule

/* rtl/rfp_back.sv */
`timescale 1ns / 1ps
module rfp_back
	import rfp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  head_t   head,
	output logic    pop,
	input  logic    out_stall,
	output logic    out_valid,
	output result_t out_word
);

	logic    valid_q;
	result_t word_q;

	assign pop       = head.valid && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || !out_stall)
			valid_q <= head.valid;
	end

	always_ff @(posedge clk) begin
		if (pop)
			word_q <= head.data;
	end

endmodule

/* rtl/rtcp_feedback_parser.sv */
`timescale 1ns / 1ps
// A result word enters the result queue as its byte is accepted, then the output register.
// Throughput: one byte per cycle unless in_stall; the output drains one word per cycle unless
// out_stall, so a final byte that also closes a NACK entry or PLI yields two output words.
// in_stall rises while the four-word result queue holds more than two words.
// Reset (arst_n low, asynchronous): parser state, queue and output valid clear at once.
module rtcp_feedback_parser
	import rfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic [15:0] datagram_length,
	input  logic        end_of_datagram,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [31:0] media_ssrc,
	output logic [15:0] lost_packet_id,
	output logic [15:0] lost_mask,
	output logic        datagram_ok,
	output logic        last_result
);

	// front: byte parser, emits up to two words per accepted byte
	// queue: decouples the parser from the output register
	// back:  output register, drained by the downstream stall
	push_t   push;
	head_t   head;
	logic    pop, full, accept;
	result_t out_word;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	rfp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.data_byte       (data_byte),
		.datagram_length (datagram_length),
		.end_of_datagram (end_of_datagram),
		.push            (push)
	);

	rfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (full)
	);

	rfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

	// unpack the output word onto the result ports
	assign event_kind     = out_word.kind;
	assign media_ssrc     = out_word.ssrc;
	assign lost_packet_id = out_word.packet_id;
	assign lost_mask      = out_word.mask;
	assign datagram_ok    = out_word.ok;
	assign last_result    = out_word.last;

endmodule

/* verif/rtcp_feedback_parser_tb.sv */
`timescale 1ns / 1ps
module rtcp_feedback_parser_tb;
	import rfp_pkg::*;

	// Random byte budget, quiet-cycle limit, receiver hold-off and tail wait.
	// The worst quiet stretch in a correct run is the hold-off (HOLD_CYCLES);
	// random stall streaks stay far below that, so QUIET_LIMIT leaves a wide margin.
	localparam int RANDOM_WORDS = 1150;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 8;

	typedef struct packed {
		logic [7:0]  data;
		logic [15:0] len;
		logic        eod;
		logic        pinned;
		logic        pinned_ok;
	} stim_row_t;

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        in_valid        = 1'b0;
	logic [7:0]  data_byte       = 8'd0;
	logic [15:0] datagram_length = 16'd0;
	logic        end_of_datagram = 1'b0;
	logic        out_stall       = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  event_kind;
	logic [31:0] media_ssrc;
	logic [15:0] lost_packet_id;
	logic [15:0] lost_mask;
	logic        datagram_ok;
	logic        last_result;

	// Parser state as the datagram walks through, widths as in the block but for pkt_start and pkt_size.
	logic [15:0] byte_index  = '0;
	logic [15:0] latched_len = '0;
	logic [17:0] pkt_start   = '0;
	logic [17:0] pkt_size    = '0;
	logic [4:0]  pkt_fmt     = '0;
	logic [7:0]  pkt_type    = '0;
	logic [31:0] ssrc_acc    = '0;
	logic [31:0] entry_acc   = '0;
	logic        dg_failed   = 1'b0;
	logic        dg_tail     = 1'b0;

	result_t     pending_results [$];
	result_t     oldest;
	stim_row_t   directed_rows [$];
	logic [7:0]  dg_bytes [$];
	logic [15:0] dg_len;

	int mismatch_count  = 0;
	int results_checked = 0;
	int idle_pct        = 0;
	int stall_pct       = 0;
	int hold_requests   = 0;
	int hold_served     = 0;
	int hold_left       = 0;
	int quiet_cycles    = 0;

	always #4 clk = ~clk;

	rtcp_feedback_parser u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.datagram_length (datagram_length),
		.end_of_datagram (end_of_datagram),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.event_kind      (event_kind),
		.media_ssrc      (media_ssrc),
		.lost_packet_id  (lost_packet_id),
		.lost_mask       (lost_mask),
		.datagram_ok     (datagram_ok),
		.last_result     (last_result)
	);

	function automatic result_t pack_event(event_kind_t kind, logic [31:0] ssrc,
		logic [15:0] id, logic [15:0] mask, logic ok);
		result_t ev;
		ev.kind      = kind;
		ev.ssrc      = ssrc;
		ev.packet_id = id;
		ev.mask      = mask;
		ev.ok        = ok;
		ev.last      = 1'b0;
		return ev;
	endfunction

	// Advance the parser state by one accepted byte and queue the result words
	// it causes. A pinned row replaces them with a status word typed in the
	// table, while the state still advances.
	task automatic predict_word(input logic [7:0] b, input logic [15:0] len,
		input logic eod, input logic pinned, input logic pinned_ok);
		logic [31:0] idx;
		logic [31:0] rel;
		logic [31:0] size;
		logic        ok;
		result_t     found [2];
		int          n;
		n   = 0;
		idx = {16'd0, byte_index};
		if (idx == 0)
			latched_len = len;
		// Any byte at or past the latched length is an overrun.
		if (idx >= {16'd0, latched_len})
			dg_failed = 1'b1;
		if (!dg_failed && !dg_tail) begin
			rel = idx - {14'd0, pkt_start};
			if (rel == 0) begin
				// Fewer than four bytes left: treat the rest as a tail.
				if ({14'd0, pkt_start} + 32'd4 > {16'd0, latched_len})
					dg_tail = 1'b1;
				else if (b[7:6] != RTCP_VERSION)
					dg_failed = 1'b1;
				else
					pkt_fmt = b[4:0];
			end else if (rel == 1) begin
				pkt_type = b;
			end else if (rel == 2) begin
				entry_acc = {24'd0, b};
			end else if (rel == 3) begin
				size = ({16'd0, entry_acc[7:0], b} + 32'd1) * 32'd4;
				if ({14'd0, pkt_start} + size > {16'd0, latched_len})
					dg_failed = 1'b1;
				else
					pkt_size = size[17:0];
			end else begin
				if (rel >= 8 && rel <= 11)
					ssrc_acc = {ssrc_acc[23:0], b};
				if (rel == 11 && pkt_type == TYPE_PLI && pkt_fmt == FMT_GENERIC &&
					pkt_size >= PLI_MIN_SIZE) begin
					found[n] = pack_event(EV_PLI, ssrc_acc, 16'd0, 16'd0, 1'b0);
					n++;
				end
				if (rel >= 12 && pkt_type == TYPE_NACK && pkt_fmt == FMT_GENERIC &&
					pkt_size >= NACK_MIN_SIZE) begin
					entry_acc = {entry_acc[23:0], b};
					if (rel[1:0] == 2'd3) begin
						found[n] = pack_event(EV_NACK, ssrc_acc, entry_acc[31:16],
							entry_acc[15:0], 1'b0);
						n++;
					end
				end
			end
			if (!dg_failed && !dg_tail && rel >= 3 && rel + 32'd1 == {14'd0, pkt_size})
				pkt_start = idx[17:0] + 18'd1;
		end
		if (eod) begin
			ok = !dg_failed && !dg_tail && (idx + 32'd1 == {16'd0, latched_len}) &&
				({14'd0, pkt_start} == idx + 32'd1);
			found[n] = pack_event(EV_STATUS, 32'd0, 16'd0, 16'd0, ok);
			n++;
			// Clear everything; the next byte opens a new datagram.
			byte_index  = '0;
			latched_len = '0;
			pkt_start   = '0;
			pkt_size    = '0;
			pkt_fmt     = '0;
			pkt_type    = '0;
			ssrc_acc    = '0;
			entry_acc   = '0;
			dg_failed   = 1'b0;
			dg_tail     = 1'b0;
		end else if (byte_index != 16'hFFFF) begin
			byte_index = byte_index + 16'd1;
		end
		if (n > 0)
			found[n - 1].last = 1'b1;
		if (pinned) begin
			found[0]      = pack_event(EV_STATUS, 32'd0, 16'd0, 16'd0, pinned_ok);
			found[0].last = 1'b1;
			pending_results.push_back(found[0]);
		end else begin
			for (int i = 0; i < n; i++)
				pending_results.push_back(found[i]);
		end
	endtask

	task automatic flag_mismatch(input string msg);
		$display("%0t: result %0d: %s", $time, results_checked, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
	endtask

	task automatic add_row(input logic [7:0] data, input logic [15:0] len,
		input logic eod, input logic pinned, input logic pinned_ok);
		stim_row_t row;
		row.data      = data;
		row.len       = len;
		row.eod       = eod;
		row.pinned    = pinned;
		row.pinned_ok = pinned_ok;
		directed_rows.push_back(row);
	endtask

	// Offer one word after a random idle gap, hold it until accepted, then
	// predict. in_valid gets one assignment per time step: a gap lowers it,
	// a back-to-back word keeps it high.
	task automatic send_word(input logic [7:0] b, input logic [15:0] len,
		input logic eod, input logic pinned, input logic pinned_ok);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		data_byte       <= b;
		datagram_length <= len;
		end_of_datagram <= eod;
		do
			@(posedge clk);
		while (in_stall);
		predict_word(b, len, eod, pinned, pinned_ok);
	endtask

	// Drop valid and hold off until every predicted word has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Append one RTCP packet with a valid version: mostly NACK or PLI with
	// sizes that yield events, sometimes undersized, odd format or other type.
	task automatic add_packet();
		int         pick;
		int         words;
		logic [7:0] ptype;
		logic [4:0] fmt;
		pick = $urandom_range(0, 9);
		fmt  = ($urandom_range(0, 9) == 0) ? 5'($urandom) : FMT_GENERIC;
		if (pick < 5) begin
			ptype = TYPE_NACK;
			words = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
		end else if (pick < 8) begin
			ptype = TYPE_PLI;
			words = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 4);
		end else begin
			ptype = 8'($urandom);
			words = $urandom_range(0, 5);
		end
		dg_bytes.push_back({RTCP_VERSION, 1'($urandom), fmt});
		dg_bytes.push_back(ptype);
		dg_bytes.push_back(8'd0);
		dg_bytes.push_back(8'(words));
		repeat ((words + 1) * 4 - 4)
			dg_bytes.push_back(8'($urandom));
	endtask

	// Build one datagram: mostly well-formed compounds, the rest broken in
	// one of several ways (bad version, short or long length, tail bytes,
	// garbage, truncation).
	task automatic build_datagram();
		int         mode;
		logic [1:0] ver;
		dg_bytes.delete();
		mode = $urandom_range(0, 19);
		repeat ($urandom_range(1, 3))
			add_packet();
		dg_len = 16'(dg_bytes.size());
		case (mode)
			0: begin
				ver = 2'($urandom_range(0, 2));
				dg_bytes[0][7:6] = (ver == RTCP_VERSION) ? 2'd3 : ver;
			end
			1: dg_len = dg_len - 16'($urandom_range(1, 4));
			2: dg_len = dg_len + 16'($urandom_range(1, 8));
			3: begin
				repeat ($urandom_range(1, 3))
					dg_bytes.push_back(8'($urandom));
				dg_len = 16'(dg_bytes.size());
			end
			4: begin
				dg_bytes.delete();
				repeat ($urandom_range(1, 6))
					dg_bytes.push_back(8'($urandom));
				case ($urandom_range(0, 3))
					0:       dg_len = 16'd0;
					1:       dg_len = 16'hFFFF;
					default: dg_len = 16'($urandom);
				endcase
			end
			5: repeat ($urandom_range(1, 3))
				void'(dg_bytes.pop_back());
			default: ;
		endcase
	endtask

	// Receiver side: a requested hold-off stalls for a long counted stretch,
	// otherwise stall at the rate of the current phase.
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left   <= HOLD_CYCLES;
			out_stall   <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Check every accepted result word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected word of kind %0d", event_kind));
			end else begin
				oldest = pending_results.pop_front();
				check_field("event_kind", 32'(event_kind), 32'(oldest.kind));
				check_field("media_ssrc", media_ssrc, oldest.ssrc);
				check_field("lost_packet_id", 32'(lost_packet_id), 32'(oldest.packet_id));
				check_field("lost_mask", 32'(lost_mask), 32'(oldest.mask));
				check_field("datagram_ok", 32'(datagram_ok), 32'(oldest.ok));
				check_field("last_result", 32'(last_result), 32'(oldest.last));
			end
			results_checked++;
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
				$display("Mismatches found");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int sent;
		int phase;
		int next_phase;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Compound of 32 bytes: PLI with all-ones SSRC, NACK
		// with padding bit, all-ones packet id and empty mask, then a header
		// whose length word runs far past the datagram.
		add_row(8'h81, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(TYPE_PLI, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(8'h00, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(8'h02, 16'd32, 1'b0, 1'b0, 1'b0);
		repeat (4) add_row(8'h00, 16'd32, 1'b0, 1'b0, 1'b0);
		repeat (4) add_row(8'hFF, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(8'hA1, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(TYPE_NACK, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(8'h00, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(8'h03, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(8'h12, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(8'h34, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(8'h56, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(8'h78, 16'd32, 1'b0, 1'b0, 1'b0);
		repeat (4) add_row(8'h00, 16'd32, 1'b0, 1'b0, 1'b0);
		repeat (2) add_row(8'hFF, 16'd32, 1'b0, 1'b0, 1'b0);
		repeat (2) add_row(8'h00, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(8'h80, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(TYPE_NACK, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(8'hFF, 16'd32, 1'b0, 1'b0, 1'b0);
		add_row(8'hFF, 16'd32, 1'b1, 1'b1, 1'b0);
		// Zero length fails on its only byte.
		add_row(8'h00, 16'd0, 1'b1, 1'b1, 1'b0);
		// Bad version at the largest length, ended early.
		add_row(8'h7F, 16'hFFFF, 1'b1, 1'b1, 1'b0);
		// Short tail of a two-byte datagram, then a byte past its end.
		add_row(8'h80, 16'd2, 1'b0, 1'b0, 1'b0);
		add_row(8'h80, 16'd2, 1'b0, 1'b0, 1'b0);
		add_row(8'hFF, 16'd2, 1'b1, 1'b1, 1'b0);

		foreach (directed_rows[i])
			send_word(directed_rows[i].data, directed_rows[i].len, directed_rows[i].eod,
				directed_rows[i].pinned, directed_rows[i].pinned_ok);
		drain_results();

		// Random part in five phases: no idling, sender idle, receiver stall,
		// both, and a long receiver hold-off while the sender keeps going.
		// Drain between phases so each starts from an empty block.
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			next_phase = sent * 5 / RANDOM_WORDS;
			if (next_phase != phase) begin
				drain_results();
				phase = next_phase;
				case (phase)
					1:       begin idle_pct = 74; stall_pct = 0;  end
					2:       begin idle_pct = 0;  stall_pct = 74; end
					3:       begin idle_pct = 23; stall_pct = 23; end
					default: begin idle_pct = 0;  stall_pct = 0;  end
				endcase
				if (phase == 4)
					hold_requests++;
			end
			build_datagram();
			// Vary the length field off the first byte; only byte zero latches it.
			for (int i = 0; i < dg_bytes.size(); i++)
				send_word(dg_bytes[i], (i == 0 || $urandom_range(0, 1)) ? dg_len : 16'($urandom),
					i == dg_bytes.size() - 1, 1'b0, 1'b0);
			sent += dg_bytes.size();
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
rtl/rfp_pkg.sv
rtl/rfp_front.sv
rtl/rfp_queue.sv
rtl/rfp_back.sv
rtl/rtcp_feedback_parser.sv
verif/rtcp_feedback_parser_tb.sv
